// ===== hdl/imh_pkg.sv =====
`default_nettype none
package imh_pkg;

    localparam int NODES  = 1024;
    localparam int NODE_W = $clog2(NODES);
    localparam int POS_W  = $clog2(NODES + 1);
    localparam int KEY_W  = 32;
    localparam int CAP_W  = 11;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_POP      = 2'd1,
        OP_DECREASE = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_CHK,
        S_DEC_CHK,
        S_DEC_KEY,
        S_UP_TEST,
        S_UP_CMP,
        S_POP_ROOT,
        S_POP_LAST,
        S_DN_TEST,
        S_DN_L,
        S_DN_R
    } state_t;

    typedef struct packed {
        op_t               operation;
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  key;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] out_node;
        logic [KEY_W-1:0]  out_key;
        status_t           status;
        logic [POS_W-1:0]  count;
    } rsp_t;

    // One heap slot holds the node together with its key.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  key;
    } slot_t;

    // Heap positions are 1-based; memory addresses are 0-based.
    function automatic logic [NODE_W-1:0] pos_to_addr(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] a;
        begin
            a = pos - POS_W'(1);
            return a[NODE_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/indexed_min_heap.sv =====
// Channel  Handshake                      Payload
// request  start, accepted when !busy     req   (operation, node, key)
// result   done, one-cycle strobe         rsp   (out_node, out_key, status, count)
// config   APB write, pready always high  pwdata[10:0] -> capacity
//
// Insert checks, then sifts up; decrease-key checks, reads the old key, then sifts up.
// Pop reads the root and the last slot, then sifts down, reading one or both children per level;
// each level is bounded by the single read port of the slot memory.
// Clear sweeps the position memory; after reset the same sweep runs while
// busy is high. Results cannot be stalled.
`default_nettype none
module indexed_min_heap import imh_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire req_t        req,
    output logic             busy,
    output logic             done,
    output rsp_t             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_we;

    assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(1024);
        end
        else if (cfg_we)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, capacity_reg} : 32'd0;

    imh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .capacity (capacity_reg),
        .busy     (busy),
        .done     (done),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire

// ===== hdl/imh_ram.sv =====
`default_nettype none
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/imh_ctrl.sv =====
`default_nettype none
module imh_ctrl import imh_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire req_t             req,
    input  wire logic [CAP_W-1:0] capacity,
    output logic                  busy,
    output logic                  done,
    output rsp_t                  rsp
);

    localparam int SLOT_W = $bits(slot_t);
    localparam int C_W    = POS_W + 1;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [POS_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  p_reg, p_next;
    logic [POS_W-1:0]  size_reg, size_next;
    slot_t             elem_reg, elem_next;
    slot_t             root_reg, root_next;
    slot_t             left_reg, left_next;
    logic [NODE_W-1:0] clr_reg, clr_next;
    logic              report_reg, report_next;
    rsp_t              rsp_reg, rsp_next;
    logic              done_reg, done_next;

    logic              slot_we;
    logic [NODE_W-1:0] slot_waddr, slot_raddr;
    slot_t             slot_wdata, slot_rdata;
    logic [SLOT_W-1:0] slot_rdata_raw;
    logic              pos_we;
    logic [NODE_W-1:0] pos_waddr, pos_raddr;
    logic [POS_W-1:0]  pos_wdata, pos_rdata;

    logic [POS_W-1:0]  eff_cap;
    logic [C_W-1:0]    c_wide;
    logic [POS_W-1:0]  c_pos, c1_pos;
    slot_t             child;
    logic [POS_W-1:0]  child_pos;
    logic              finish;
    status_t           status_v;

    imh_ram #(.WIDTH(SLOT_W), .DEPTH(NODES)) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata_raw)
    );
    assign slot_rdata = slot_t'(slot_rdata_raw);

    imh_ram #(.WIDTH(POS_W), .DEPTH(NODES)) u_pos (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    assign eff_cap = (capacity > CAP_W'(NODES)) ? POS_W'(NODES) : POS_W'(capacity);
    assign c_wide  = {p_reg, 1'b0};
    assign c_pos   = c_wide[POS_W-1:0];
    assign c1_pos  = c_pos + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            count_reg  <= '0;
            clr_reg    <= '0;
            report_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            clr_reg    <= clr_next;
            report_reg <= report_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        p_reg    <= p_next;
        size_reg <= size_next;
        elem_reg <= elem_next;
        root_reg <= root_next;
        left_reg <= left_next;
        rsp_reg  <= rsp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        count_next  = count_reg;
        p_next      = p_reg;
        size_next   = size_reg;
        elem_next   = elem_reg;
        root_next   = root_reg;
        left_next   = left_reg;
        clr_next    = clr_reg;
        report_next = report_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        finish      = 1'b0;
        status_v    = ST_OK;
        slot_we     = 1'b0;
        slot_waddr  = pos_to_addr(p_reg);
        slot_wdata  = elem_reg;
        slot_raddr  = '0;
        pos_we      = 1'b0;
        pos_waddr   = elem_reg.node;
        pos_wdata   = p_reg;
        pos_raddr   = req.node;
        child       = slot_rdata;
        child_pos   = c_pos;

        case (state_reg)
            S_CLEAR:
            begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == {NODE_W{1'b1}})
                begin
                    if (report_reg)
                    begin
                        finish = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    case (req.operation)
                        OP_INSERT:   state_next = S_INS_CHK;
                        OP_DECREASE: state_next = S_DEC_CHK;
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_v = ST_EMPTY;
                                finish   = 1'b1;
                            end
                            else
                            begin
                                slot_raddr = '0;
                                state_next = S_POP_ROOT;
                            end
                        end
                        default:
                        begin
                            count_next  = '0;
                            clr_next    = '0;
                            report_next = 1'b1;
                            state_next  = S_CLEAR;
                        end
                    endcase
                end
            end
            S_INS_CHK:
            begin
                if (pos_rdata != '0)
                begin
                    status_v   = ST_ABSENT;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (count_reg >= eff_cap)
                begin
                    status_v   = ST_FULL;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    count_next = count_reg + POS_W'(1);
                    p_next     = count_reg + POS_W'(1);
                    elem_next  = '{node: req_reg.node, key: req_reg.key};
                    state_next = S_UP_TEST;
                end
            end
            S_DEC_CHK:
            begin
                if (pos_rdata == '0)
                begin
                    status_v   = ST_ABSENT;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    p_next     = pos_rdata;
                    slot_raddr = pos_to_addr(pos_rdata);
                    state_next = S_DEC_KEY;
                end
            end
            S_DEC_KEY:
            begin
                if (req_reg.key <= slot_rdata.key)
                begin
                    elem_next  = '{node: req_reg.node, key: req_reg.key};
                    state_next = S_UP_TEST;
                end
                else
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_UP_TEST:
            begin
                if (p_reg == POS_W'(1))
                begin
                    slot_we    = 1'b1;
                    pos_we     = 1'b1;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_raddr = pos_to_addr(p_reg >> 1);
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                // The moving entry stays in a register; the parent drops into the hole.
                if (slot_rdata.key > elem_reg.key)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = slot_rdata.node;
                    p_next     = p_reg >> 1;
                    state_next = S_UP_TEST;
                end
                else
                begin
                    slot_we    = 1'b1;
                    pos_we     = 1'b1;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP_ROOT:
            begin
                root_next  = slot_rdata;
                slot_raddr = pos_to_addr(count_reg);
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                elem_next  = slot_rdata;
                pos_we     = 1'b1;
                pos_waddr  = root_reg.node;
                pos_wdata  = '0;
                count_next = count_reg - POS_W'(1);
                size_next  = count_reg - POS_W'(1);
                p_next     = POS_W'(1);
                if (count_reg == POS_W'(1))
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_TEST;
                end
            end
            S_DN_TEST:
            begin
                if (c_wide > C_W'(size_reg))
                begin
                    slot_we    = 1'b1;
                    pos_we     = 1'b1;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_raddr = pos_to_addr(c_pos);
                    state_next = S_DN_L;
                end
            end
            S_DN_L, S_DN_R:
            begin
                if (state_reg == S_DN_L && c_pos < size_reg)
                begin
                    left_next  = slot_rdata;
                    slot_raddr = pos_to_addr(c1_pos);
                    state_next = S_DN_R;
                end
                else
                begin
                    if (state_reg == S_DN_R)
                    begin
                        // On a tie the left child stays chosen.
                        if (left_reg.key > slot_rdata.key)
                        begin
                            child     = slot_rdata;
                            child_pos = c1_pos;
                        end
                        else
                        begin
                            child     = left_reg;
                            child_pos = c_pos;
                        end
                    end
                    if (elem_reg.key > child.key)
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = child;
                        pos_we     = 1'b1;
                        pos_waddr  = child.node;
                        p_next     = child_pos;
                        state_next = S_DN_TEST;
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        pos_we     = 1'b1;
                        finish     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next        = 1'b1;
            rsp_next.status  = status_v;
            rsp_next.count   = count_next;
            rsp_next.out_node = '0;
            rsp_next.out_key  = '0;
            if (status_v == ST_OK && req_reg.operation == OP_POP)
            begin
                rsp_next.out_node = root_reg.node;
                rsp_next.out_key  = root_reg.key;
            end
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire
